// ===== rtl/modified_utf8_string_decoder_assert.svh =====
// Assertion macros used by the checker file of the decoder.
`ifndef MODIFIED_UTF8_STRING_DECODER_ASSERT_SVH
`define MODIFIED_UTF8_STRING_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MU8_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MU8_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication that is also checked across reset.
`define MU8_ASSERT_NXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

// ===== rtl/mu8_pkg.sv =====
// Types and codes shared by the modified UTF-8 decoder files.
package mu8_pkg;

  localparam logic [2:0] ST_CHAR   = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_FORMAT = 3'd2;
  localparam logic [2:0] ST_TRUNC  = 3'd3;
  localparam logic [2:0] ST_EOS    = 3'd4;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [15:0] char_code;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } mu8_res_t;

endpackage

// ===== rtl/mu8_core.sv =====
// Decoder state and the per-byte decode logic.
module mu8_core
  import mu8_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t in_data,
  input  logic     cfg_write,
  input  logic     cfg_data,
  output mu8_res_t res
);

  localparam logic [2:0] PH_LEN_HI = 3'd0;
  localparam logic [2:0] PH_LEN_LO = 3'd1;
  localparam logic [2:0] PH_LEAD   = 3'd2;
  localparam logic [2:0] PH_SECOND = 3'd3;
  localparam logic [2:0] PH_THIRD  = 3'd4;

  logic        single_char_mode;
  logic [2:0]  phase, phase_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  lead_byte, lead_byte_next;
  logic [7:0]  middle_byte, middle_byte_next;

  logic [2:0]  ph;
  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] bl;
  logic        done;

  function automatic logic is_cont(input logic [7:0] v);
    return v[7:6] == 2'b10;
  endfunction

  always_comb begin
    b                = in_data.byte_value;
    len              = {length_high, b};
    bl               = single_char_mode ? bytes_left : bytes_left - 16'd1;
    done             = single_char_mode || (bl == 16'd0);
    phase_next       = phase;
    length_high_next = length_high;
    bytes_left_next  = bytes_left;
    lead_byte_next   = lead_byte;
    middle_byte_next = middle_byte;
    res              = '0;

    // Unused phase codes act as idle; in single mode idle means waiting for a lead.
    ph = (phase > PH_THIRD) ? PH_LEN_HI : phase;
    if (single_char_mode && (ph < PH_LEAD)) ph = PH_LEAD;

    if (in_data.end_of_stream) begin
      res.valid       = 1'b1;
      res.item.status = ST_EOS;
      res.item.last   = 1'b1;
      phase_next      = PH_LEN_HI;
    end else begin
      case (ph)
        PH_LEN_HI: begin
          length_high_next = b;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len == 16'd0) begin
            res.valid       = 1'b1;
            res.item.status = ST_EMPTY;
            res.item.last   = 1'b1;
            phase_next      = PH_LEN_HI;
          end else begin
            bytes_left_next = len;
            phase_next      = PH_LEAD;
          end
        end
        PH_LEAD: begin
          bytes_left_next = bl;
          if (is_cont(b) || (b[7:4] == 4'hF)) begin
            res.valid       = 1'b1;
            res.item.status = ST_FORMAT;
            res.item.last   = 1'b1;
            phase_next      = PH_LEN_HI;
          end else if (!b[7]) begin
            res.valid          = 1'b1;
            res.item.char_code = {8'd0, b};
            res.item.status    = ST_CHAR;
            res.item.last      = done;
            phase_next         = done ? PH_LEN_HI : PH_LEAD;
          end else if (!single_char_mode && (bl == 16'd0)) begin
            res.valid       = 1'b1;
            res.item.status = ST_TRUNC;
            res.item.last   = 1'b1;
            phase_next      = PH_LEN_HI;
          end else begin
            lead_byte_next = b;
            phase_next     = PH_SECOND;
          end
        end
        PH_SECOND: begin
          bytes_left_next = bl;
          if (lead_byte[7:5] == 3'b110) begin
            if (!is_cont(b)) begin
              res.valid       = 1'b1;
              res.item.status = ST_FORMAT;
              res.item.last   = 1'b1;
              phase_next      = PH_LEN_HI;
            end else begin
              res.valid          = 1'b1;
              res.item.char_code = {5'd0, lead_byte[4:0], b[5:0]};
              res.item.status    = ST_CHAR;
              res.item.last      = done;
              phase_next         = done ? PH_LEN_HI : PH_LEAD;
            end
          end else if (!single_char_mode && (bl == 16'd0)) begin
            res.valid       = 1'b1;
            res.item.status = ST_TRUNC;
            res.item.last   = 1'b1;
            phase_next      = PH_LEN_HI;
          end else begin
            middle_byte_next = b;
            phase_next       = PH_THIRD;
          end
        end
        default: begin
          // Third byte of a three-byte group: both continuations checked here.
          bytes_left_next = bl;
          if (!is_cont(middle_byte) || !is_cont(b)) begin
            res.valid       = 1'b1;
            res.item.status = ST_FORMAT;
            res.item.last   = 1'b1;
            phase_next      = PH_LEN_HI;
          end else begin
            res.valid          = 1'b1;
            res.item.char_code = {lead_byte[3:0], middle_byte[5:0], b[5:0]};
            res.item.status    = ST_CHAR;
            res.item.last      = done;
            phase_next         = done ? PH_LEN_HI : PH_LEAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      single_char_mode <= 1'b0;
      phase            <= PH_LEN_HI;
      length_high      <= 8'd0;
      bytes_left       <= 16'd0;
      lead_byte        <= 8'd0;
      middle_byte      <= 8'd0;
    end else if (cfg_write) begin
      // A mode write drops any partial string or character.
      single_char_mode <= cfg_data;
      phase            <= PH_LEN_HI;
      bytes_left       <= 16'd0;
    end else if (accept) begin
      phase       <= phase_next;
      length_high <= length_high_next;
      bytes_left  <= bytes_left_next;
      lead_byte   <= lead_byte_next;
      middle_byte <= middle_byte_next;
    end
  end

endmodule

// ===== rtl/mu8_out_reg.sv =====
// Result register between the decode logic and the output channel.
module mu8_out_reg
  import mu8_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mu8_res_t  res,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic accept;

  // Requests enter when no result is held or the held one leaves in the same cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_data <= res.item;
    end
  end

endmodule

// ===== rtl/modified_utf8_string_decoder.sv =====
// Top level of the modified UTF-8 string decoder.
//
// The input channel (in_valid, in_ready, in_data) takes one stream byte or an
// end-of-stream mark per request. In string mode two big-endian bytes give the
// byte length of the string, then its bytes follow; in single-character mode
// each one-, two- or three-byte group stands alone. The output channel
// (out_valid, out_ready, out_data) gives one 16-bit character per completed
// group, or a status for an empty string, an error or an end-of-stream mark,
// with last marking the final result of a string or character. Requests that
// complete nothing give no result. One request is taken per cycle while
// in_ready is high; a result appears in the cycle after the byte that
// completes it, held in the result register. If the receiver stalls, the
// result waits there and in_ready drops until it is taken. Reset clears the
// decoder to wait for a length header in string mode and empties the result
// register. cfg_write loads single_char_mode and abandons any partial string.
module modified_utf8_string_decoder
  import mu8_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_write,
  input  logic      cfg_data
);

  mu8_res_t res;

  mu8_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_valid && in_ready),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  mu8_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/mu8_checker.sv =====
// Port-level checks on the decoder and the bind that attaches them.
`include "modified_utf8_string_decoder_assert.svh"

module mu8_checker
  import mu8_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `MU8_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `MU8_ASSERT_IMP(a_err_last, out_valid && (out_data.status != ST_CHAR), out_data.last)
  `MU8_ASSERT_IMP(a_err_zero, out_valid && (out_data.status != ST_CHAR),
                  out_data.char_code == 16'd0)
  `MU8_ASSERT_IMP(a_status, out_valid, out_data.status <= ST_EOS)
  `MU8_ASSERT_NXT_RST(a_reset, rst, !out_valid && in_ready)

endmodule

bind modified_utf8_string_decoder mu8_checker u_chk (.*);
